### rtl/rmth_pkg.sv
// ============================================================================
// Running median package
// Payload types shared by the running median block and its users.
// ============================================================================
package rmth_pkg;

    localparam int unsigned ValueWidth = 32;

    typedef struct packed {
        logic signed [ValueWidth-1:0] sample_value;
        logic                         starts_case;
    } t_in;

    typedef struct packed {
        logic signed [ValueWidth-1:0] median_value;
        logic                         overflowed;
    } t_out;

endpackage

### rtl/running_median_two_heaps.sv
// ============================================================================
// Running median in two heaps
// A max-heap of the lower half and a min-heap of the upper half, each held in
// a single-port synchronous memory; the median is the upper heap's top.
// ============================================================================
// A starting beat is taken and busy does not rise.
// A later beat keeps busy high through an insert, then possibly a pop and an
// insert to rebalance, or through a drop when its heap is already full.
// One beat is in work at a time, so the next beat is taken once busy falls.
// The result strobe is the last busy cycle and cannot be stalled by the receiver.
// Reset is synchronous and active low; it empties both heaps at once.
module running_median_two_heaps #(
    parameter int unsigned HEAP_DEPTH = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rmth_pkg::t_in   i_item,
    output logic            o_valid,
    output rmth_pkg::t_out  o_result
);

    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned VW = rmth_pkg::ValueWidth;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TOP    = 4'd1;  // read upper top, wait
    localparam logic [3:0] S_DEC    = 4'd2;  // choose heap, start push
    localparam logic [3:0] S_UPRD   = 4'd3;  // sift-up: parent read issued
    localparam logic [3:0] S_UPCMP  = 4'd4;  // sift-up: compare with parent
    localparam logic [3:0] S_POPRD  = 4'd5;  // pop: read top and last
    localparam logic [3:0] S_POPLST = 4'd6;
    localparam logic [3:0] S_DNL    = 4'd7;  // sift-down: left child read
    localparam logic [3:0] S_DNR    = 4'd8;  // sift-down: right child read
    localparam logic [3:0] S_DNCMP  = 4'd9;
    localparam logic [3:0] S_REBAL  = 4'd10; // choose rebalance step
    localparam logic [3:0] S_FIN    = 4'd11; // read upper top for result
    localparam logic [3:0] S_OUT    = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13; // result strobe

    // Heap memories.
    logic [VW-1:0] r_lo_mem [HEAP_DEPTH];
    logic [VW-1:0] r_up_mem [HEAP_DEPTH];
    logic [VW-1:0] r_lo_q, r_up_q;

    logic          m_we, m_sel_up;
    logic [AW-1:0] m_addr;
    logic [VW-1:0] m_wd;

    always_ff @(posedge i_clk) begin
        if (m_we && !m_sel_up) begin
            r_lo_mem[m_addr] <= m_wd;
        end
        r_lo_q <= r_lo_mem[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we && m_sel_up) begin
            r_up_mem[m_addr] <= m_wd;
        end
        r_up_q <= r_up_mem[m_addr];
    end

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_lo_cnt, n_lo_cnt, r_up_cnt, n_up_cnt;
    logic                r_ovf, n_ovf;
    logic signed [VW-1:0] r_val, n_val;   // value being sifted
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW:0]         r_chl, n_chl;    // child index (wider to detect end)
    logic signed [VW-1:0] r_best, n_best;
    logic [AW:0]         r_bidx, n_bidx;
    logic                r_heap_up, n_heap_up;
    logic                r_phase, n_phase; // 0 insert, 1 rebalance insert
    logic                r_drop, n_drop;
    logic                r_valid, n_valid;
    logic signed [VW-1:0] r_med, n_med;

    logic [VW-1:0] rd_q;
    assign rd_q = r_heap_up ? r_up_q : r_lo_q;

    // a sits above b in the current heap
    function automatic logic above(input logic signed [VW-1:0] a,
                                   input logic signed [VW-1:0] b,
                                   input logic up);
        above = up ? (a < b) : (a > b);
    endfunction

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = r_heap_up ? r_up_cnt : r_lo_cnt;

    // Total number of stored values, one bit wider so that it cannot wrap.
    logic [CW:0] tot;
    assign tot = {1'b0, r_lo_cnt} + {1'b0, r_up_cnt};

    always_comb begin
        n_state = r_state; n_lo_cnt = r_lo_cnt; n_up_cnt = r_up_cnt;
        n_ovf = r_ovf; n_val = r_val; n_idx = r_idx; n_chl = r_chl;
        n_best = r_best; n_bidx = r_bidx; n_heap_up = r_heap_up;
        n_phase = r_phase; n_drop = r_drop; n_valid = 1'b0; n_med = r_med;
        m_we = 1'b0; m_sel_up = r_heap_up; m_addr = r_idx; m_wd = r_val;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val = i_item.sample_value;
                    n_drop = 1'b0;
                    n_phase = 1'b0;
                    if (i_item.starts_case) begin
                        m_we = 1'b1; m_sel_up = 1'b1; m_addr = '0;
                        m_wd = i_item.sample_value;
                        n_up_cnt = CW'(1); n_lo_cnt = '0; n_ovf = 1'b0;
                    end else begin
                        m_sel_up = 1'b1; m_addr = '0;
                        n_state = S_TOP;
                    end
                end
            end
            S_TOP: begin
                m_sel_up = 1'b1; m_addr = '0;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_heap_up = !((r_up_cnt != '0) && (r_val < $signed(r_up_q)));
                if ((n_heap_up ? r_up_cnt : r_lo_cnt) == CW'(HEAP_DEPTH)) begin
                    n_ovf = 1'b1; n_drop = 1'b1; n_state = S_FIN;
                end else begin
                    n_idx = n_heap_up ? r_up_cnt[AW-1:0] : r_lo_cnt[AW-1:0];
                    if (n_heap_up) n_up_cnt = r_up_cnt + 1'b1;
                    else           n_lo_cnt = r_lo_cnt + 1'b1;
                    m_sel_up = n_heap_up; m_addr = n_idx; m_we = 1'b1;
                    n_state = S_UPRD;
                end
            end
            S_UPRD: begin
                // Value r_val sits at r_idx; read parent.
                if (r_idx == '0) begin
                    n_state = r_phase ? S_FIN : S_REBAL;
                end else begin
                    m_addr = AW'((r_idx - 1'b1) >> 1);
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (above(r_val, $signed(rd_q), r_heap_up)) begin
                    // swap: parent value down to r_idx, value up to parent
                    m_we = 1'b1; m_addr = r_idx; m_wd = rd_q;
                    n_idx = AW'((r_idx - 1'b1) >> 1);
                    n_state = S_POPLST; // write value at new index next
                    n_phase = r_phase;
                    n_bidx = '0;
                end else begin
                    n_state = r_phase ? S_FIN : S_REBAL;
                end
            end
            S_POPLST: begin
                if (r_bidx == '0) begin
                    // sift-up continuation: place value at new index
                    m_we = 1'b1; m_addr = r_idx; m_wd = r_val;
                    n_state = S_UPRD;
                end else begin
                    // pop: last element arrives, write to root
                    n_val = $signed(rd_q);
                    m_we = 1'b1; m_addr = '0; m_wd = rd_q;
                    n_idx = '0;
                    n_state = S_DNL;
                end
            end
            S_REBAL: begin
                if (r_lo_cnt > r_up_cnt) begin
                    n_heap_up = 1'b0; m_sel_up = 1'b0; m_addr = '0;
                    n_state = S_POPRD;
                end else if (r_up_cnt > r_lo_cnt + 1'b1) begin
                    n_heap_up = 1'b1; m_sel_up = 1'b1; m_addr = '0;
                    n_state = S_POPRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POPRD: begin
                // top is now on rd_q
                n_med = $signed(rd_q);
                if (r_heap_up) n_up_cnt = r_up_cnt - 1'b1;
                else           n_lo_cnt = r_lo_cnt - 1'b1;
                m_addr = AW'(cur_cnt - 1'b1);
                n_bidx = (AW+1)'(1);
                n_state = S_POPLST;
            end
            S_DNL: begin
                n_chl = {r_idx, 1'b1};
                if ({1'b0, r_idx, 1'b1} >= (AW+2)'(cur_cnt)) begin
                    n_state = S_DNCMP; // push of popped value
                    n_bidx = '0;
                    n_chl = '1;
                end else begin
                    m_addr = AW'({r_idx, 1'b1});
                    n_best = r_val; n_bidx = {1'b0, r_idx};
                    n_state = S_DNR;
                end
            end
            S_DNR: begin
                if (above($signed(rd_q), r_best, r_heap_up)) begin
                    n_best = $signed(rd_q); n_bidx = r_chl;
                end
                if ((AW+1)'(r_chl + 1'b1) < (AW+1)'(cur_cnt)) begin
                    m_addr = AW'(r_chl + 1'b1);
                    n_chl = r_chl + 1'b1;
                    n_state = S_DNCMP;
                end else begin
                    n_chl = '0;
                    n_state = S_DNCMP;
                end
            end
            S_DNCMP: begin
                if (r_chl == '1) begin
                    // sift-down done: push popped top into other heap
                    n_heap_up = !r_heap_up;
                    n_val = r_med;
                    n_phase = 1'b1;
                    n_idx = r_heap_up ? r_lo_cnt[AW-1:0] : r_up_cnt[AW-1:0];
                    if (r_heap_up) n_lo_cnt = r_lo_cnt + 1'b1;
                    else           n_up_cnt = r_up_cnt + 1'b1;
                    m_sel_up = !r_heap_up; m_addr = n_idx; m_wd = r_med;
                    m_we = 1'b1;
                    n_state = S_UPRD;
                end else begin
                    if (r_chl != '0 &&
                        above($signed(rd_q), r_best, r_heap_up)) begin
                        n_best = $signed(rd_q); n_bidx = r_chl;
                    end
                    if (n_bidx == {1'b0, r_idx}) begin
                        n_chl = '1;
                    end else begin
                        m_we = 1'b1; m_addr = r_idx; m_wd = n_best;
                        n_idx = n_bidx[AW-1:0];
                        n_bidx = (AW+1)'(1);
                        n_state = S_OUT; // write value at new index
                    end
                end
            end
            S_OUT: begin
                // place the sifted value at its new slot, then go on
                m_we = 1'b1; m_addr = r_idx; m_wd = r_val;
                n_state = S_DNL;
            end
            S_FIN: begin
                // The upper top read here is on r_up_q during the strobe.
                m_sel_up = 1'b1; m_addr = '0;
                n_heap_up = 1'b1;
                n_state = S_IDLE;
                if (r_drop || (tot[0] && tot >= (CW+1)'(3))) begin
                    n_valid = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_lo_cnt <= '0; r_up_cnt <= '0;
            r_ovf <= 1'b0; r_valid <= 1'b0; r_heap_up <= 1'b1;
        end else begin
            r_state <= n_state; r_lo_cnt <= n_lo_cnt; r_up_cnt <= n_up_cnt;
            r_ovf <= n_ovf; r_valid <= n_valid; r_heap_up <= n_heap_up;
        end
        r_val <= n_val; r_idx <= n_idx; r_chl <= n_chl; r_best <= n_best;
        r_bidx <= n_bidx; r_phase <= n_phase; r_drop <= n_drop; r_med <= n_med;
    end

    assign busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result.median_value = (r_up_cnt != '0) ? $signed(r_up_q) : '0;
    assign o_result.overflowed   = r_ovf;

    a_cnt_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_cnt <= CW'(HEAP_DEPTH)) else $error("lower count beyond depth");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up_cnt <= CW'(HEAP_DEPTH)) else $error("upper count beyond depth");
    a_bal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_up_cnt >= r_lo_cnt)) else $error("heaps out of balance");

endmodule

### tb/sv/running_median_two_heaps_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median checker
// Watches the input and result channels of the running median block. It keeps
// its own pair of heaps, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module running_median_two_heaps_chk #(
    parameter int unsigned HEAP_DEPTH = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  rmth_pkg::t_in   i_item,
    input  logic            i_valid,
    input  rmth_pkg::t_out  i_result,
    output int              o_errors,
    output int              o_pending
);
    localparam int unsigned ValueWidth = rmth_pkg::ValueWidth;

    localparam int LowerHalf = 0;
    localparam int UpperHalf = 1;

    logic signed [ValueWidth-1:0] halves [2][HEAP_DEPTH];
    int unsigned                  fill [2];
    bit                           dropped_any;
    rmth_pkg::t_out               medians_due [$];

    // Lower half is a max-heap, upper half a min-heap.
    function automatic bit outranks(logic signed [ValueWidth-1:0] a,
                                    logic signed [ValueWidth-1:0] b, int h);
        return (h == LowerHalf) ? (a > b) : (a < b);
    endfunction

    function automatic void heap_insert(int h, logic signed [ValueWidth-1:0] v);
        int unsigned i;
        int unsigned p;
        logic signed [ValueWidth-1:0] t;
        i = fill[h];
        halves[h][i] = v;
        fill[h] = i + 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!outranks(halves[h][i], halves[h][p], h)) break;
            t = halves[h][i]; halves[h][i] = halves[h][p]; halves[h][p] = t;
            i = p;
        end
    endfunction

    function automatic logic signed [ValueWidth-1:0] heap_take(int h);
        int unsigned n;
        int unsigned i;
        int unsigned l;
        int unsigned best;
        logic signed [ValueWidth-1:0] top;
        logic signed [ValueWidth-1:0] t;
        top = halves[h][0];
        n = fill[h] - 1;
        halves[h][0] = halves[h][n];
        fill[h] = n;
        i = 0;
        forever begin
            l = 2 * i + 1;
            best = i;
            if (l < n && outranks(halves[h][l], halves[h][best], h)) best = l;
            if (l + 1 < n && outranks(halves[h][l + 1], halves[h][best], h)) best = l + 1;
            if (best == i) break;
            t = halves[h][i]; halves[h][i] = halves[h][best]; halves[h][best] = t;
            i = best;
        end
        return top;
    endfunction

    function automatic void predict_median(rmth_pkg::t_in beat);
        int h;
        bit lost;
        rmth_pkg::t_out r;
        if (beat.starts_case) begin
            fill[LowerHalf] = 0;
            fill[UpperHalf] = 0;
            dropped_any = 1'b0;
            heap_insert(UpperHalf, beat.sample_value);
            return;
        end
        h = (fill[UpperHalf] > 0 && beat.sample_value < halves[UpperHalf][0]) ?
            LowerHalf : UpperHalf;
        lost = fill[h] >= HEAP_DEPTH;
        if (lost) begin
            dropped_any = 1'b1;
        end else begin
            heap_insert(h, beat.sample_value);
            if (fill[LowerHalf] > fill[UpperHalf])
                heap_insert(UpperHalf, heap_take(LowerHalf));
            else if (fill[UpperHalf] > fill[LowerHalf] + 1)
                heap_insert(LowerHalf, heap_take(UpperHalf));
        end
        if (lost || ((fill[LowerHalf] + fill[UpperHalf]) % 2 == 1 &&
                     fill[LowerHalf] + fill[UpperHalf] >= 3)) begin
            r.median_value = (fill[UpperHalf] > 0) ? halves[UpperHalf][0] : '0;
            r.overflowed   = dropped_any;
            medians_due.push_back(r);
        end
    endfunction

    // Results are checked before a beat accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        rmth_pkg::t_out want;
        if (!i_rst_n) begin
            fill[LowerHalf] = 0;
            fill[UpperHalf] = 0;
            dropped_any = 1'b0;
            medians_due.delete();
            o_errors = 0;
        end else begin
            if (i_valid) begin
                if (medians_due.size() == 0) begin
                    $display("%0t: unexpected result median=%0d overflowed=%0b", $time,
                             i_result.median_value, i_result.overflowed);
                    o_errors++;
                end else begin
                    want = medians_due.pop_front();
                    if (i_result.median_value !== want.median_value) begin
                        $display("%0t: median_value expected %0d actual %0d", $time,
                                 want.median_value, i_result.median_value);
                        o_errors++;
                    end
                    if (i_result.overflowed !== want.overflowed) begin
                        $display("%0t: overflowed expected %0b actual %0b", $time,
                                 want.overflowed, i_result.overflowed);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) predict_median(i_item);
        end
        o_pending = medians_due.size();
    end

endmodule

### tb/sv/running_median_two_heaps_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median testbench
// Drives directed and random sample beats into the running median block, with
// phases of sender idling, and takes its verdict from the checker beside it.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    rmth_pkg::t_in  i_item;
    logic           o_valid;
    rmth_pkg::t_out o_result;
    int             errors;
    int             pending;
    int             idle_pct;

    running_median_two_heaps dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    running_median_two_heaps_chk chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_item   (i_item),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A generous ceiling: the slowest correct run needs only a few ms.
    initial begin
        #40ms;
        $display("running_median_two_heaps_tb failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken, so that start stays high between back-to-back beats.
    task automatic send_sample(logic signed [rmth_pkg::ValueWidth-1:0] v, logic s);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item.sample_value <= v;
        i_item.starts_case  <= s;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Mixes full-range values with clustered ones so that ties and near ties
    // between the two halves turn up often.
    function automatic logic signed [rmth_pkg::ValueWidth-1:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $signed($urandom_range(20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    // A case of the given length, starting with a case-start beat.
    task automatic run_case(int len);
        send_sample(pick_value(), 1'b1);
        for (int k = 1; k < len; k++) send_sample(pick_value(), 1'b0);
    endtask

    initial begin
        int waited;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Values before any case start are predicted and checked too.
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd3, 1'b0);
        send_sample(32'sd9, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        // A starting beat never gives a result; then extremes and equal values.
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sh55555555, 1'b1);
        send_sample(32'shaaaaaaaa, 1'b0);
        send_sample(32'sh55555555, 1'b0);
        send_sample(32'sh55555555, 1'b1);
        send_sample(32'sd7, 1'b1);

        // Random part: short cases under each idling phase.
        idle_pct = 0;
        for (int c = 0; c < 10; c++) run_case($urandom_range(1, 8));
        idle_pct = 86;
        for (int c = 0; c < 8; c++) run_case($urandom_range(1, 6));
        idle_pct = 15;
        for (int c = 0; c < 8; c++) run_case($urandom_range(1, 8));
        // Stray values, some of them case starts, kept short.
        idle_pct = 0;
        repeat (10) send_sample(pick_value(), $urandom_range(3) == 0);

        // One long case fills a heap; later values are dropped and flagged,
        // from either half, until a new case clears the flag.
        run_case(1040);
        run_case(5);

        start <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("running_median_two_heaps_tb passed");
        else
            $display("running_median_two_heaps_tb failed");
        $finish;
    end

endmodule
